FILE: rtl/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants of the crank cadence meter
// widths, fixed-point scale factors and the divider request bundle
// ----------------------------------------------------------------------------
package ccm_pkg;

    localparam int ANGLE_W   = 16;
    localparam int TIME_W    = 32;
    localparam int CAD_W     = 16;
    localparam int ADV_W     = 32;

    // cadence = advance*60000/(360*elapsed) = advance*500/(3*elapsed)
    localparam int NUM_W     = ADV_W + 9;      // advance * 500
    localparam int DEN_W     = TIME_W + 2;     // elapsed * 3
    localparam int CNT_W     = 4;              // one count per quotient bit

    localparam logic [ADV_W-1:0] CDEG_PER_TURN = ADV_W'(36000);
    localparam logic [CAD_W-1:0] CADENCE_MAX   = {CAD_W{1'b1}};
    localparam logic [ANGLE_W-1:0] MIN_ADV_RESET = ANGLE_W'(3000);

    typedef struct packed {
        logic              start;
        logic [ADV_W-1:0]  advance;
        logic [TIME_W-1:0] elapsed;
    } ccm_div_req_t;

endpackage

FILE: rtl/ccm_div.sv
// ----------------------------------------------------------------------------
// ccm_div: bit-serial cadence divider
// scales advance and elapsed time, then develops a saturating 16-bit
// quotient one bit per cycle by restoring division
// ----------------------------------------------------------------------------
module ccm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ccm_pkg::ccm_div_req_t      req,
    output logic                       done,
    output logic [ccm_pkg::CAD_W-1:0]  quot
);

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_SCALE = 5'b00010,
        D_CHECK = 5'b00100,
        D_ITER  = 5'b01000,
        D_DONE  = 5'b10000
    } div_state_t;

    div_state_t                    state_reg, state_next;
    logic [ccm_pkg::ADV_W-1:0]     adv_reg;
    logic [ccm_pkg::TIME_W-1:0]    ela_reg;
    logic [ccm_pkg::NUM_W-1:0]     num_reg;
    logic [ccm_pkg::DEN_W-1:0]     den_reg;
    logic [ccm_pkg::DEN_W-1:0]     rem_reg;
    logic [ccm_pkg::CAD_W-1:0]     quot_reg;
    logic [ccm_pkg::CNT_W-1:0]     cnt_reg;

    logic [ccm_pkg::NUM_W-1:0]     num_scaled;
    logic [ccm_pkg::DEN_W-1:0]     den_scaled;
    logic [ccm_pkg::DEN_W-1:0]     rem_top;
    logic [ccm_pkg::DEN_W:0]       trial;
    logic [ccm_pkg::DEN_W+1:0]     diff;
    logic                          fits;

    // 500 = 512 - 8 - 4, 3 = 2 + 1
    assign num_scaled = (ccm_pkg::NUM_W'(adv_reg) << 9)
                      - (ccm_pkg::NUM_W'(adv_reg) << 3)
                      - (ccm_pkg::NUM_W'(adv_reg) << 2);
    assign den_scaled = (ccm_pkg::DEN_W'(ela_reg) << 1) + ccm_pkg::DEN_W'(ela_reg);

    // high dividend bits above the 16 quotient positions
    assign rem_top = ccm_pkg::DEN_W'(num_reg[ccm_pkg::NUM_W-1:ccm_pkg::CAD_W]);

    assign trial = {rem_reg, num_reg[ccm_pkg::CAD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = ~diff[ccm_pkg::DEN_W+1];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (req.start) state_next = D_SCALE;
            D_SCALE: state_next = D_CHECK;
            D_CHECK: state_next = (rem_top >= den_reg) ? D_DONE : D_ITER;
            D_ITER:  if (cnt_reg == '0) state_next = D_DONE;
            D_DONE:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    adv_reg <= req.advance;
                    ela_reg <= req.elapsed;
                end
            end
            D_SCALE:
            begin
                num_reg <= num_scaled;
                den_reg <= den_scaled;
            end
            D_CHECK:
            begin
                // zero elapsed time lands here too, since anything >= 0
                if (rem_top >= den_reg)
                begin
                    quot_reg <= ccm_pkg::CADENCE_MAX;
                end
                else
                begin
                    rem_reg <= rem_top;
                    cnt_reg <= {ccm_pkg::CNT_W{1'b1}};
                end
            end
            D_ITER:
            begin
                rem_reg  <= fits ? diff[ccm_pkg::DEN_W-1:0] : trial[ccm_pkg::DEN_W-1:0];
                num_reg  <= num_reg << 1;
                quot_reg <= {quot_reg[ccm_pkg::CAD_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == D_DONE);
    assign quot = quot_reg;

endmodule

FILE: rtl/crank_cadence_meter_core.sv
// ----------------------------------------------------------------------------
// crank_cadence_meter_core: crank cadence in centi-rpm from angle samples
// forms the forward angle advance and elapsed ms against a stored reference
// and recomputes cadence once the advance reaches the programmed threshold
// ----------------------------------------------------------------------------
// restart or below-threshold beats give their result in the cycle after accept
// recomputing beats pass through load, scale, overflow check, the 16 quotient bits of
//   the bit-serial divider, done and writeback, which waits for the result register
// overflow or zero elapsed time skips the quotient bits
// throughput: one beat in flight; next beat accepted once the result register frees
// reset: rst_n async low; references and held cadence clear to zero, threshold to 3000
// ----------------------------------------------------------------------------
module crank_cadence_meter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [ccm_pkg::ANGLE_W-1:0]   cfg_wdata,
    // sample channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ccm_pkg::ANGLE_W-1:0]   angle_cdeg,
    input  logic [ccm_pkg::TIME_W-1:0]    time_ms,
    input  logic                          restart,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ccm_pkg::CAD_W-1:0]     cadence_centi_rpm,
    output logic                          updated
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // waiting for a sample beat
        ST_DIV  = 3'b010,   // divider running
        ST_WB   = 3'b100    // new cadence waiting for the result register
    } state_t;

    state_t                         state_reg;
    logic [ccm_pkg::ANGLE_W-1:0]    min_adv_reg;
    logic [ccm_pkg::ANGLE_W-1:0]    ref_angle_reg;
    logic [ccm_pkg::TIME_W-1:0]     ref_time_reg;
    logic [ccm_pkg::CAD_W-1:0]      held_reg;
    logic                           out_valid_reg;
    logic [ccm_pkg::CAD_W-1:0]      out_cad_reg;
    logic                           out_upd_reg;

    logic                           accept;
    logic                           out_free;
    logic [ccm_pkg::ADV_W-1:0]      advance;
    logic                           do_calc;
    ccm_pkg::ccm_div_req_t          div_req;
    logic                           div_done;
    logic [ccm_pkg::CAD_W-1:0]      div_quot;

    // result register is free when empty or being drained this cycle
    assign out_free = ~out_valid_reg | out_ready;
    assign in_ready = (state_reg == ST_IDLE) & out_free;
    assign accept   = in_valid & in_ready;

    // forward advance on raw 16-bit angles; the wrap case is taken modulo 2^32
    // so out-of-range angles give the same huge advance as plain unsigned math
    always_comb
    begin
        if (angle_cdeg > ref_angle_reg)
        begin
            advance = ccm_pkg::ADV_W'(angle_cdeg) - ccm_pkg::ADV_W'(ref_angle_reg);
        end
        else if (angle_cdeg == ref_angle_reg)
        begin
            advance = '0;
        end
        else
        begin
            advance = ccm_pkg::ADV_W'(angle_cdeg) + ccm_pkg::CDEG_PER_TURN
                    - ccm_pkg::ADV_W'(ref_angle_reg);
        end
    end

    // a zero threshold lets an equal angle recompute too
    assign do_calc = ~restart & (advance >= ccm_pkg::ADV_W'(min_adv_reg));

    assign div_req.start   = accept & do_calc;
    assign div_req.advance = advance;
    assign div_req.elapsed = time_ms - ref_time_reg;   // wraps modulo 2^32

    ccm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // threshold register; write it only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_adv_reg <= ccm_pkg::MIN_ADV_RESET;
        end
        else if (cfg_we)
        begin
            min_adv_reg <= cfg_wdata;
        end
    end

    // sequencer and reference state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_angle_reg <= '0;
            ref_time_reg  <= '0;
            held_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // restart and recompute both move the reference to this sample
                    if (accept && (restart || do_calc))
                    begin
                        ref_angle_reg <= angle_cdeg;
                        ref_time_reg  <= time_ms;
                    end
                    if (accept && do_calc)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        held_reg  <= div_quot;
                        state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register: held cadence goes out at once, a new one after the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((accept && !do_calc) || (state_reg == ST_WB && out_free))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !do_calc)
        begin
            out_cad_reg <= held_reg;
            out_upd_reg <= 1'b0;
        end
        else if (state_reg == ST_WB && out_free)
        begin
            out_cad_reg <= held_reg;
            out_upd_reg <= 1'b1;
        end
    end

    assign out_valid         = out_valid_reg;
    assign cadence_centi_rpm = out_cad_reg;
    assign updated           = out_upd_reg;

endmodule

FILE: rtl/ccm_chk.sv
// ----------------------------------------------------------------------------
// ccm_chk: port-level checks for the crank cadence meter
// watches the sample and result channels of the top level
// ----------------------------------------------------------------------------
module ccm_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          restart,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ccm_pkg::CAD_W-1:0]     cadence_centi_rpm,
    input  logic                          updated
);

    logic [ccm_pkg::CAD_W-1:0] last_cad_reg;

    // cadence of the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cad_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_cad_reg <= cadence_centi_rpm;
        end
    end

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cadence_centi_rpm)
            && $stable(updated))
        else $error("result changed while stalled");

    // a restart beat yields a non-updated result on the next cycle
    a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> out_valid && !updated)
        else $error("restart beat did not give a held result");

    // a held result repeats the last delivered cadence
    a_held_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !updated |-> cadence_centi_rpm == last_cad_reg)
        else $error("held cadence differs from last result");

    // after a beat the block either shows a result or stops taking samples
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid || !in_ready)
        else $error("second sample taken while one is in flight");

endmodule

bind crank_cadence_meter_core ccm_chk u_ccm_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .restart           (restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cadence_centi_rpm (cadence_centi_rpm),
    .updated           (updated)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the crank cadence meter core
// drives angle/timestamp beats with random gaps and back-pressure, predicts
// each cadence beat in a behavioral model or the directed table, and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    // fixed-point scale: centidegrees in, centi-rpm out
    localparam longint unsigned RPM_NUM      = 60000;
    localparam longint unsigned RPM_DEN      = 360;
    localparam int              ANGLE_SPAN   = 36000;
    localparam logic [ccm_pkg::ANGLE_W-1:0] MIN_ADV_TOP = ccm_pkg::ANGLE_W'(36000);

    // run shape
    localparam int PLAN_LEN       = 22;
    localparam int PHASES         = 13;
    localparam int PHASE_BEATS    = 155;
    localparam int SHORT_BEATS    = 60;      // phase where nothing in range can reach the threshold
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam int RUN_LIMIT_NS   = 20_000_000;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    // one directed row: a sample beat or a threshold write
    // typed rows carry the expected result read straight off the spec
    typedef struct packed {
        row_kind_t                    kind;
        logic [ccm_pkg::ANGLE_W-1:0]  value;     // angle, or threshold for a write
        logic [ccm_pkg::TIME_W-1:0]   stamp;
        logic                         restart;
        logic                         typed;
        logic [ccm_pkg::CAD_W-1:0]    cad;
        logic                         upd;
    } plan_row_t;

    typedef struct packed {
        logic [ccm_pkg::CAD_W-1:0] cad;
        logic                      upd;
    } cadence_beat_t;

    // ------------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------------
    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ccm_pkg::ANGLE_W-1:0]   cfg_wdata;
    logic                          in_valid;
    logic                          in_ready;
    logic [ccm_pkg::ANGLE_W-1:0]   angle_cdeg;
    logic [ccm_pkg::TIME_W-1:0]    time_ms;
    logic                          restart;
    logic                          out_valid;
    logic                          out_ready;
    logic [ccm_pkg::CAD_W-1:0]     cadence_centi_rpm;
    logic                          updated;

    crank_cadence_meter_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .angle_cdeg        (angle_cdeg),
        .time_ms           (time_ms),
        .restart           (restart),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .cadence_centi_rpm (cadence_centi_rpm),
        .updated           (updated)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // cadence predictor state, kept in step with the accepted sample beats
    // ------------------------------------------------------------------------
    logic [ccm_pkg::ANGLE_W-1:0] min_adv_model   = ccm_pkg::MIN_ADV_RESET;
    logic [ccm_pkg::ANGLE_W-1:0] ref_angle_model = '0;
    logic [ccm_pkg::TIME_W-1:0]  ref_time_model  = '0;
    logic [ccm_pkg::CAD_W-1:0]   held_cad_model  = '0;

    cadence_beat_t cadence_due [$];     // expected cadence beats, oldest first

    int  beats_in;
    int  beats_out;
    int  mismatches;
    int  recomputes;
    int  saturations;
    int  restarts_sent;
    int  settings;
    bit  no_idle;                       // phase-wide switch: no gaps on either side

    // forward advance with wrap at one turn; out-of-range angles go through raw
    function automatic cadence_beat_t next_cadence(
        input logic [ccm_pkg::ANGLE_W-1:0] ang,
        input logic [ccm_pkg::TIME_W-1:0]  stamp,
        input logic                        rs);
        cadence_beat_t                beat;
        logic [ccm_pkg::ADV_W-1:0]    adv;
        logic [ccm_pkg::TIME_W-1:0]   elapsed;
        longint unsigned              quot;
        beat.upd = 1'b0;
        if (rs)
        begin
            ref_angle_model = ang;
            ref_time_model  = stamp;
        end
        else
        begin
            if (ang > ref_angle_model)
                adv = ccm_pkg::ADV_W'(ang) - ccm_pkg::ADV_W'(ref_angle_model);
            else if (ang == ref_angle_model)
                adv = '0;
            else
                adv = ccm_pkg::ADV_W'(ang) + ccm_pkg::CDEG_PER_TURN
                    - ccm_pkg::ADV_W'(ref_angle_model);

            if (adv >= ccm_pkg::ADV_W'(min_adv_model))
            begin
                elapsed = stamp - ref_time_model;
                if (elapsed == '0)
                    held_cad_model = ccm_pkg::CADENCE_MAX;
                else
                begin
                    quot = (longint'(adv) * RPM_NUM) / (longint'(elapsed) * RPM_DEN);
                    held_cad_model = (quot > longint'(ccm_pkg::CADENCE_MAX))
                                   ? ccm_pkg::CADENCE_MAX
                                   : ccm_pkg::CAD_W'(quot);
                end
                ref_angle_model = ang;
                ref_time_model  = stamp;
                beat.upd = 1'b1;
            end
        end
        beat.cad = held_cad_model;
        return beat;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at result beat %0d: %s expected %0d got %0d",
                     beats_out, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // sender side, all tasks entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        in_valid = 1'b0;
        while (cadence_due.size() != 0)
            @(negedge clk);
    endtask

    // threshold writes only with nothing in flight
    task automatic write_min_advance(input logic [ccm_pkg::ANGLE_W-1:0] thr);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = thr;
        @(negedge clk);
        cfg_we    = 1'b0;
        min_adv_model = thr;
        settings++;
    endtask

    task automatic send_sample(input logic [ccm_pkg::ANGLE_W-1:0] ang,
                               input logic [ccm_pkg::TIME_W-1:0] stamp,
                               input logic rs, input logic typed,
                               input cadence_beat_t typed_beat);
        cadence_beat_t due;
        int            gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        // predictor runs in send order, which is also accept order
        due = next_cadence(ang, stamp, rs);
        if (typed)
            due = typed_beat;
        cadence_due.push_back(due);
        if (due.upd)
            recomputes++;
        if (due.upd && due.cad == ccm_pkg::CADENCE_MAX)
            saturations++;
        if (rs)
            restarts_sent++;

        in_valid   = 1'b1;
        angle_cdeg = ang;
        time_ms    = stamp;
        restart    = rs;
        do
            @(posedge clk);
        while (!in_ready);
        beats_in++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // directed rows: reset state, extremes, wrap, saturation, threshold edges
    // ------------------------------------------------------------------------
    plan_row_t plan [PLAN_LEN] = '{
        // no restart since reset, equal angle below threshold
        '{ROW_SAMPLE, 16'd0,     32'd0,          1'b0, 1'b1, 16'd0,     1'b0},
        // zero elapsed time saturates
        '{ROW_SAMPLE, 16'd3000,  32'd0,          1'b0, 1'b1, 16'hFFFF,  1'b1},
        // restart repeats the held cadence
        '{ROW_SAMPLE, 16'd0,     32'd1000,       1'b1, 1'b1, 16'hFFFF,  1'b0},
        '{ROW_SAMPLE, 16'd18000, 32'd2000,       1'b0, 1'b1, 16'd3000,  1'b1},
        // angle wraps past zero
        '{ROW_SAMPLE, 16'd1000,  32'd3000,       1'b0, 1'b0, 16'd0,     1'b0},
        // below threshold, held value repeats
        '{ROW_SAMPLE, 16'd1500,  32'd3000,       1'b0, 1'b0, 16'd0,     1'b0},
        // quotient overflow
        '{ROW_SAMPLE, 16'd35999, 32'd3001,       1'b0, 1'b1, 16'hFFFF,  1'b1},
        '{ROW_SAMPLE, 16'd0,     32'hFFFF_FF00,  1'b1, 1'b1, 16'hFFFF,  1'b0},
        // timestamp wraps
        '{ROW_SAMPLE, 16'd30000, 32'h0000_0100,  1'b0, 1'b0, 16'd0,     1'b0},
        // out-of-range angle, then a huge wrapped advance
        '{ROW_SAMPLE, 16'hFFFF,  32'h0000_0200,  1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_SAMPLE, 16'd0,     32'h0000_0300,  1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_SAMPLE, 16'd35999, 32'hFFFF_FFFF,  1'b1, 1'b0, 16'd0,     1'b0},
        // longest elapsed time truncates to zero
        '{ROW_SAMPLE, 16'd35998, 32'hFFFF_FFFE,  1'b0, 1'b1, 16'd0,     1'b1},
        // threshold zero: equal angle still recomputes
        '{ROW_CFG,    16'd0,     32'd0,          1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_SAMPLE, 16'd35998, 32'hFFFF_FFFE,  1'b0, 1'b1, 16'hFFFF,  1'b1},
        '{ROW_SAMPLE, 16'd35998, 32'hFFFF_FFFF,  1'b0, 1'b1, 16'd0,     1'b1},
        // top threshold: a full in-range turn is not enough
        '{ROW_CFG,    16'd36000, 32'd0,          1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_SAMPLE, 16'd0,     32'd0,          1'b1, 1'b1, 16'd0,     1'b0},
        '{ROW_SAMPLE, 16'd35999, 32'd1000,       1'b0, 1'b1, 16'd0,     1'b0},
        '{ROW_SAMPLE, 16'hFFFF,  32'h8000_0000,  1'b0, 1'b1, 16'd0,     1'b1},
        '{ROW_CFG,    16'd3000,  32'd0,          1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_SAMPLE, 16'd3000,  32'h8000_0001,  1'b0, 1'b0, 16'd0,     1'b0}
    };

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int                           phase;
        int                           k;
        int                           n_beats;
        int                           r;
        int                           s_angle;
        logic [ccm_pkg::TIME_W-1:0]   s_time;
        logic [ccm_pkg::ANGLE_W-1:0]  thr;
        cadence_beat_t                typed_beat;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        angle_cdeg = '0;
        time_ms    = '0;
        restart    = 1'b0;
        no_idle    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table first, starting on the reset threshold
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_min_advance(plan[i].value);
            else
            begin
                typed_beat.cad = plan[i].cad;
                typed_beat.upd = plan[i].upd;
                send_sample(plan[i].value, plan[i].stamp, plan[i].restart, plan[i].typed,
                            typed_beat);
            end
        end

        // random phases, each on its own threshold
        typed_beat = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                thr = '0;
            else if (phase == 1)
                thr = MIN_ADV_TOP;
            else if (phase == 2)
                thr = ccm_pkg::MIN_ADV_RESET;
            else if ($urandom_range(0, 3) == 0)
                thr = ccm_pkg::ANGLE_W'($urandom_range(0, ANGLE_SPAN));
            else
                thr = ccm_pkg::ANGLE_W'($urandom_range(0, 6000));
            n_beats = (phase == 1) ? SHORT_BEATS : PHASE_BEATS;
            write_min_advance(thr);
            no_idle = (phase == 3) || ($urandom_range(0, 4) == 0);

            // every phase opens with a restart on a random crank position
            s_angle = $urandom_range(0, ANGLE_SPAN - 1);
            s_time  = $urandom;
            send_sample(ccm_pkg::ANGLE_W'(s_angle), s_time, 1'b1, 1'b0, typed_beat);

            for (k = 1; k < n_beats; k++)
            begin
                // now and then drain the pipe completely before going on
                if ($urandom_range(0, 149) == 0)
                    wait_idle();
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    // crank turning forward, mostly short sample spacing
                    s_angle = (s_angle + $urandom_range(0, 9000)) % ANGLE_SPAN;
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        s_time = s_time;
                    else if (r < 10)
                        s_time = s_time + $urandom;
                    else
                        s_time = s_time + $urandom_range(1, 200);
                    send_sample(ccm_pkg::ANGLE_W'(s_angle), s_time, 1'b0, 1'b0,
                                typed_beat);
                end
                else if (r < 87)
                begin
                    // restart, half the time from a fresh position
                    if ($urandom_range(0, 1) == 0)
                    begin
                        s_angle = $urandom_range(0, ANGLE_SPAN - 1);
                        s_time  = $urandom;
                    end
                    send_sample(ccm_pkg::ANGLE_W'(s_angle), s_time, 1'b1, 1'b0,
                                typed_beat);
                end
                else if (r < 95)
                begin
                    // noise: any 16-bit angle, any stamp, either restart value
                    send_sample(ccm_pkg::ANGLE_W'($urandom_range(0, 65535)), $urandom,
                                1'($urandom_range(0, 1)), 1'b0, typed_beat);
                end
                else
                begin
                    // small backward step, looks like almost a full turn forward
                    s_angle = (s_angle + ANGLE_SPAN - $urandom_range(1, 2000)) % ANGLE_SPAN;
                    s_time  = s_time + $urandom_range(1, 50);
                    send_sample(ccm_pkg::ANGLE_W'(s_angle), s_time, 1'b0, 1'b0,
                                typed_beat);
                end
            end
        end

        // drain, then give a late or extra beat time to show up
        no_idle = 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("run covered %0d sample beats (%0d restarts) over %0d threshold settings",
                 beats_in, restarts_sent, settings);
        $display("%0d cadence recomputes, %0d of them saturated, %0d mismatches",
                 recomputes, saturations, mismatches);
        if (mismatches == 0 && cadence_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver side: random back-pressure, changes at the falling edge
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready  = 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check on every accepted result beat, oldest expectation first
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        cadence_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (cadence_due.size() == 0)
                flag_mismatch("unexpected result beat, cadence", 0, cadence_centi_rpm);
            else
            begin
                want = cadence_due.pop_front();
                if (cadence_centi_rpm !== want.cad)
                    flag_mismatch("cadence_centi_rpm", want.cad, cadence_centi_rpm);
                if (updated !== want.upd)
                    flag_mismatch("updated", want.upd, updated);
            end
        end
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d result beats still outstanding", cadence_due.size());
        $display("testbench failed");
        $finish;
    end

endmodule
